[hdl/led_effect_sequencer_top_assert.svh]
// Assertion macros for the LED effect sequencer checker.
`ifndef LED_EFFECT_SEQUENCER_TOP_ASSERT_SVH
`define LED_EFFECT_SEQUENCER_TOP_ASSERT_SVH

// Clocked assertion, muted while reset is held.
`define LES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LES_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[hdl/les_pkg.sv]
package les_pkg;

    localparam int DEF_QUEUE_DEPTH = 10;
    localparam int DEF_DUTY_WIDTH  = 13;
    localparam int ADDR_W          = 4;
    localparam int DATA_W          = 32;

    localparam logic       ACT_TICK = 1'b0;
    localparam logic       ACT_TRIG = 1'b1;

    localparam logic [1:0] EFF_BREATH = 2'd0;
    localparam logic [1:0] EFF_QUICK  = 2'd1;
    localparam logic [1:0] EFF_SLOW   = 2'd2;
    localparam logic [1:0] EFF_NONE   = 2'd3;

    localparam logic [1:0] REG_BREATH = 2'd0;
    localparam logic [1:0] REG_QUICK  = 2'd1;
    localparam logic [1:0] REG_SLOW   = 2'd2;
    localparam logic [1:0] REG_OFF    = 2'd3;

    localparam logic [9:0]  BREATH_HOLD_RST = 10'd20;
    localparam logic [9:0]  QUICK_HOLD_RST  = 10'd100;
    localparam logic [11:0] SLOW_HOLD_RST   = 12'd1000;
    localparam int          OFF_DUTY_RST    = 8191;

    localparam logic [6:0] BREATH_STEPS   = 7'd64;
    localparam logic [6:0] BLINK_STEPS    = 7'd2;
    localparam logic [3:0] BREATH_REPEATS = 4'd5;
    localparam logic [3:0] QUICK_REPEATS  = 4'd10;
    localparam logic [3:0] SLOW_REPEATS   = 4'd3;

    typedef struct packed {
        logic       trig;
        logic [1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [9:0]  breath;
        logic [9:0]  quick;
        logic [11:0] slow;
    } t_hold;

    typedef struct packed {
        logic       push;
        logic [1:0] code;
        logic       pop;
    } t_fifo_ctl;

    typedef struct packed {
        logic       has_real;
        logic [1:0] head_code;
    } t_fifo_stat;

endpackage

[hdl/les_in_if.sv]
interface les_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [1:0] effect_code;

    modport source (output valid, output action, output effect_code, input ready);
    modport sink (input valid, input action, input effect_code, output ready);
endinterface

[hdl/les_out_if.sv]
interface les_out_if import les_pkg::*; #(
    parameter int DUTY_W = DEF_DUTY_WIDTH,
    parameter int CNT_W  = $clog2(DEF_QUEUE_DEPTH + 1)
);
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              busy_res;
    logic              dropped;
    logic [CNT_W-1:0]  queued;

    modport source (output valid, output duty, output busy_res, output dropped,
                    output queued, input ready);
    modport sink (input valid, input duty, input busy_res, input dropped,
                  input queued, output ready);
endinterface

[hdl/les_effect_fifo.sv]
module les_effect_fifo import les_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_fifo_ctl        i_ctl,
    output t_fifo_stat       o_stat,
    output logic [CNT_W-1:0] o_count
);

    // Only real effects are stored; each keeps the number of ignored codes
    // queued right before it so that one pop can retire them together.
    logic [1:0]       r_code [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_pre3 [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_real;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_trail;

    logic             push_real;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_inc;

    assign push_real = i_ctl.push && (i_ctl.code != EFF_NONE);
    assign head_inc  = (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_inc  = (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;

    always_ff @(posedge i_clk) begin
        if (push_real) begin
            r_code[r_tail] <= i_ctl.code;
            r_pre3[r_tail] <= r_trail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_real  <= '0;
            r_count <= '0;
            r_trail <= '0;
        end else if (i_ctl.push) begin
            r_count <= r_count + 1'b1;
            if (push_real) begin
                r_real  <= r_real + 1'b1;
                r_tail  <= tail_inc;
                r_trail <= '0;
            end else begin
                r_trail <= r_trail + 1'b1;
            end
        end else if (i_ctl.pop) begin
            if (r_real != '0) begin
                r_count <= r_count - r_pre3[r_head] - 1'b1;
                r_real  <= r_real - 1'b1;
                r_head  <= head_inc;
            end else begin
                // only ignored codes wait: drop them all
                r_count <= '0;
                r_trail <= '0;
            end
        end
    end

    assign o_stat.has_real  = (r_real != '0);
    assign o_stat.head_code = r_code[r_head];
    assign o_count          = r_count;

endmodule

[hdl/les_front.sv]
module les_front import les_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    les_in_if.sink i_in,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic accept;
    t_cmd cmd_in;

    assign i_in.ready  = (r_cnt != 2'd2);
    assign accept      = i_in.valid && i_in.ready;
    assign cmd_in.trig = (i_in.action == ACT_TRIG);
    assign cmd_in.code = i_in.effect_code;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (accept) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, accept} - {1'b0, i_cmd_take};
        end
    end

    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

endmodule

[hdl/les_player.sv]
module les_player import les_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int DUTY_WIDTH  = DEF_DUTY_WIDTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_cmd_take,
    input  t_hold                 i_hold,
    input  logic [DUTY_WIDTH-1:0] i_off_duty,
    les_out_if.source             o_out
);

    localparam logic [DUTY_WIDTH-1:0] FULL_DUTY = {DUTY_WIDTH{1'b1}};
    localparam int SH = DUTY_WIDTH - 5;

    logic                  r_out_valid;
    logic                  r_busy;
    logic [1:0]            r_eff;
    logic [3:0]            r_rep;
    logic [5:0]            r_step;
    logic [11:0]           r_timer;
    logic [DUTY_WIDTH-1:0] r_duty;
    logic                  r_dropped;

    logic                  n_busy;
    logic [1:0]            n_eff;
    logic [3:0]            n_rep;
    logic [5:0]            n_step;
    logic [11:0]           n_timer;
    logic [DUTY_WIDTH-1:0] n_duty;
    logic                  n_dropped;

    t_fifo_ctl        ctl_raw;
    t_fifo_ctl        fifo_ctl;
    t_fifo_stat       fifo_stat;
    logic [CNT_W-1:0] fifo_count;

    logic        take;
    logic [11:0] hold_raw;
    logic [11:0] hold;
    logic [12:0] timer_inc;
    logic [6:0]  step_inc;
    logic [3:0]  rep_inc;
    logic [3:0]  reps;
    logic        step_done;
    logic        last_step;
    logic        last_rep;

    function automatic logic [DUTY_WIDTH-1:0] level_of(input logic [1:0] eff,
                                                      input logic [5:0] step);
        logic [DUTY_WIDTH-1:0] ramp;
        ramp = {step[4:0], {SH{1'b0}}};
        if (eff == EFF_BREATH) begin
            level_of = step[5] ? ramp : FULL_DUTY - ramp;
        end else begin
            level_of = (step == 6'd0) ? FULL_DUTY : '0;
        end
    endfunction

    les_effect_fifo #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .o_stat  (fifo_stat),
        .o_count (fifo_count)
    );

    assign take       = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign o_cmd_take = take;

    always_comb begin
        case (r_eff)
            EFF_BREATH: begin
                hold_raw = {2'b00, i_hold.breath};
                reps     = BREATH_REPEATS;
            end
            EFF_QUICK: begin
                hold_raw = {2'b00, i_hold.quick};
                reps     = QUICK_REPEATS;
            end
            default: begin
                hold_raw = i_hold.slow;
                reps     = SLOW_REPEATS;
            end
        endcase
    end

    // a hold of zero acts as one tick
    assign hold      = (hold_raw == '0) ? 12'd1 : hold_raw;
    assign timer_inc = {1'b0, r_timer} + 13'd1;
    assign step_done = (timer_inc >= {1'b0, hold});
    assign step_inc  = {1'b0, r_step} + 7'd1;
    assign last_step = (step_inc == ((r_eff == EFF_BREATH) ? BREATH_STEPS : BLINK_STEPS));
    assign rep_inc   = r_rep + 4'd1;
    assign last_rep  = (rep_inc >= reps);

    always_comb begin
        n_busy    = r_busy;
        n_eff     = r_eff;
        n_rep     = r_rep;
        n_step    = r_step;
        n_timer   = r_timer;
        n_duty    = r_duty;
        n_dropped = 1'b0;
        ctl_raw   = '0;
        if (i_cmd.trig) begin
            if (fifo_count >= CNT_W'(QUEUE_DEPTH)) begin
                n_dropped = 1'b1;
            end else if (r_busy) begin
                ctl_raw.push = 1'b1;
                ctl_raw.code = i_cmd.code;
            end else if (i_cmd.code != EFF_NONE) begin
                // idle: start at once, queue stays empty
                n_busy  = 1'b1;
                n_eff   = i_cmd.code;
                n_rep   = '0;
                n_step  = '0;
                n_timer = '0;
                n_duty  = FULL_DUTY;
            end
        end else if (r_busy) begin
            if (step_done) begin
                n_timer = '0;
                if (last_step) begin
                    n_step = '0;
                    if (last_rep) begin
                        ctl_raw.pop = 1'b1;
                        if (fifo_stat.has_real) begin
                            n_eff  = fifo_stat.head_code;
                            n_rep  = '0;
                            n_duty = FULL_DUTY;
                        end else begin
                            n_busy = 1'b0;
                        end
                    end else begin
                        n_rep  = rep_inc;
                        n_duty = level_of(r_eff, 6'd0);
                    end
                end else begin
                    n_step = step_inc[5:0];
                    n_duty = level_of(r_eff, step_inc[5:0]);
                end
            end else begin
                n_timer = timer_inc[11:0];
            end
        end
        if (!n_busy) begin
            n_duty = i_off_duty;
        end
    end

    assign fifo_ctl = take ? ctl_raw : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
            r_eff       <= EFF_BREATH;
            r_rep       <= '0;
            r_step      <= '0;
            r_timer     <= '0;
            r_duty      <= FULL_DUTY;
            r_dropped   <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_busy      <= n_busy;
                r_eff       <= n_eff;
                r_rep       <= n_rep;
                r_step      <= n_step;
                r_timer     <= n_timer;
                r_duty      <= n_duty;
                r_dropped   <= n_dropped;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // state only moves on take, so the live state is the pending word
    assign o_out.valid    = r_out_valid;
    assign o_out.duty     = r_duty;
    assign o_out.busy_res = r_busy;
    assign o_out.dropped  = r_dropped;
    assign o_out.queued   = fifo_count;

endmodule

[hdl/led_effect_sequencer_top.sv]
// An input word waits in the two-word command queue, which accepts input
// while o_out is stalled until full; the one-step player update registers
// its result on o_out at one word per cycle while o_out is not stalled.
// Reset (i_rst_n low, synchronous): queues empty, player idle, registers to
// their defaults; the effect store needs no clearing.
module led_effect_sequencer_top import les_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int DUTY_WIDTH  = DEF_DUTY_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    les_in_if.sink            i_in,
    les_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int FULL_INT = (1 << DUTY_WIDTH) - 1;
    localparam logic [DUTY_WIDTH-1:0] OFF_RST =
        DUTY_WIDTH'((FULL_INT < OFF_DUTY_RST) ? FULL_INT : OFF_DUTY_RST);

    t_hold                 r_hold;
    logic [DUTY_WIDTH-1:0] r_off_duty;

    logic       cmd_valid;
    t_cmd       cmd;
    logic       cmd_take;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.breath <= BREATH_HOLD_RST;
            r_hold.quick  <= QUICK_HOLD_RST;
            r_hold.slow   <= SLOW_HOLD_RST;
            r_off_duty    <= OFF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BREATH: r_hold.breath <= pwdata[9:0];
                REG_QUICK:  r_hold.quick  <= pwdata[9:0];
                REG_SLOW:   r_hold.slow   <= pwdata[11:0];
                REG_OFF:    r_off_duty    <= pwdata[DUTY_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_BREATH: prdata = {{(DATA_W - 10){1'b0}}, r_hold.breath};
            REG_QUICK:  prdata = {{(DATA_W - 10){1'b0}}, r_hold.quick};
            REG_SLOW:   prdata = {{(DATA_W - 12){1'b0}}, r_hold.slow};
            REG_OFF:    prdata = {{(DATA_W - DUTY_WIDTH){1'b0}}, r_off_duty};
            default:    prdata = '0;
        endcase
    end

    les_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    les_player #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .DUTY_WIDTH  (DUTY_WIDTH)
    ) u_player (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_hold      (r_hold),
        .i_off_duty  (r_off_duty),
        .o_out       (o_out)
    );

endmodule

[hdl/les_checker.sv]
`include "led_effect_sequencer_top_assert.svh"

module les_checker import les_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int DUTY_WIDTH  = DEF_DUTY_WIDTH,
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [DUTY_WIDTH-1:0] i_duty,
    input logic                  i_busy_res,
    input logic                  i_dropped,
    input logic [CNT_W-1:0]      i_queued
);

    // a lost trigger only happens against a full queue
    `LES_ASSERT(a_drop_full, i_out_valid && i_dropped |-> i_queued == CNT_W'(QUEUE_DEPTH), "drop without full queue")
    // an idle player has drained the queue
    `LES_ASSERT(a_idle_empty, i_out_valid && !i_busy_res |-> i_queued == '0, "idle with queued effects")
    // hold a stalled word
    `LES_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_duty) && $stable(i_queued), "stalled word changed")
    `LES_ASSERT_NR(a_rst_quiet, !i_rst_n |=> !i_out_valid, "word valid after reset")

endmodule

bind led_effect_sequencer_top les_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DUTY_WIDTH  (DUTY_WIDTH)
) u_les_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_duty      (o_out.duty),
    .i_busy_res  (o_out.busy_res),
    .i_dropped   (o_out.dropped),
    .i_queued    (o_out.queued)
);
